// ===== rtl/fhc_pkg.sv =====
package fhc_pkg;

  localparam int MaxFrameBytes = 65535;

  typedef enum logic [1:0] {
    PH_LINK = 2'd0,
    PH_IP4  = 2'd1,
    PH_IP6  = 2'd2,
    PH_DONE = 2'd3
  } phase_t;

  localparam logic [1:0] LINK_NULL = 2'd0;
  localparam logic [1:0] LINK_ETH  = 2'd1;
  localparam logic [1:0] LINK_RAW  = 2'd2;
  localparam logic [1:0] LINK_SLL  = 2'd3;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_TRUNC   = 3'd1;
  localparam logic [2:0] ST_ETYPE   = 3'd2;
  localparam logic [2:0] ST_PROTO   = 3'd3;
  localparam logic [2:0] ST_NOETYPE = 3'd4;

  localparam logic [2:0] K_TCP4 = 3'd0;
  localparam logic [2:0] K_UDP4 = 3'd1;
  localparam logic [2:0] K_ICMP4 = 3'd2;
  localparam logic [2:0] K_TCP6 = 3'd3;
  localparam logic [2:0] K_UDP6 = 3'd4;
  localparam logic [2:0] K_ICMP6 = 3'd5;

  localparam logic [15:0] ET_IP4  = 16'h0800;
  localparam logic [15:0] ET_IP6  = 16'h86dd;
  localparam logic [15:0] ET_VLAN = 16'h8100;

  typedef struct packed {
    logic [2:0]  status;
    logic [2:0]  flow_kind;
    logic [15:0] ip_offset;
    logic [15:0] payload_offset;
    logic [15:0] payload_length;
    logic [63:0] source_high;
    logic [63:0] source_low;
    logic [63:0] dest_high;
    logic [63:0] dest_low;
    logic [15:0] source_port;
    logic [15:0] dest_port;
  } result_t;

  // end-of-frame snapshot handed from front to back
  typedef struct packed {
    phase_t      phase;
    logic [1:0]  link_type;
    logic [2:0]  error_code;
    logic [16:0] byte_count;
    logic [16:0] ip_start;
    logic [7:0]  hdr_bytes;
    logic [15:0] len_field;
    logic [7:0]  proto;
    logic [63:0] addr0;
    logic [63:0] addr1;
    logic [63:0] addr2;
    logic [63:0] addr3;
    logic [15:0] port0;
    logic [15:0] port1;
  } snap_t;

endpackage

// ===== rtl/frame_header_classifier.sv =====
// frame header classifier: one frame byte per cycle in, one result per frame out
// the result of a frame passes the front snapshot, judge and queue registers before it shows at the queue head
// throughput: 1 byte per cycle while full is low; full rises only while two or more results wait in the
//   4-entry result queue, which frames of a byte or two can cause when pop stays low
// reset: synchronous, link_type returns to ethernet and the frame restarts
module frame_header_classifier #(
  parameter int MAX_FRAME_BYTES = fhc_pkg::MaxFrameBytes
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_data,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  frame_byte,
  input  logic        last_byte,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  status,
  output logic [2:0]  flow_kind,
  output logic [15:0] ip_offset,
  output logic [15:0] payload_offset,
  output logic [15:0] payload_length,
  output logic [63:0] source_high,
  output logic [63:0] source_low,
  output logic [63:0] dest_high,
  output logic [63:0] dest_low,
  output logic [15:0] source_port,
  output logic [15:0] dest_port
);

  logic [1:0]        link_reg;
  logic              take;
  logic              snap_valid;
  fhc_pkg::snap_t    snap;
  logic              res_valid;
  fhc_pkg::result_t  res;
  fhc_pkg::result_t  head;
  logic              almost_full;

  // link type register
  always_ff @(posedge clk) begin
    if (rst) begin
      link_reg <= fhc_pkg::LINK_ETH;
    end else if (cfg_we) begin
      link_reg <= cfg_data;
    end
  end

  assign take = push && !full;
  assign full = almost_full;

  fhc_front #(.MAX_FRAME_BYTES(MAX_FRAME_BYTES)) u_front (
    .clk(clk), .rst(rst), .link_type(link_reg), .restart(cfg_we),
    .take(take), .frame_byte(frame_byte), .last_byte(last_byte),
    .snap_valid(snap_valid), .snap(snap)
  );

  fhc_judge u_judge (
    .clk(clk), .rst(rst), .snap_valid(snap_valid), .snap(snap),
    .res_valid(res_valid), .res(res)
  );

  fhc_queue #(.DEPTH(4)) u_queue (
    .clk(clk), .rst(rst), .wr(res_valid), .wdata(res), .rd(pop),
    .empty(empty), .almost_full(almost_full), .rdata(head)
  );

  assign status = head.status;
  assign flow_kind = head.flow_kind;
  assign ip_offset = head.ip_offset;
  assign payload_offset = head.payload_offset;
  assign payload_length = head.payload_length;
  assign source_high = head.source_high;
  assign source_low = head.source_low;
  assign dest_high = head.dest_high;
  assign dest_low = head.dest_low;
  assign source_port = head.source_port;
  assign dest_port = head.dest_port;

  // checks
  a_snap_to_res: assert property (@(posedge clk) disable iff (rst)
    snap_valid |=> res_valid) else $error("judge dropped an item");
  a_last_snap: assert property (@(posedge clk) disable iff (rst)
    (take && last_byte) |=> snap_valid) else $error("front lost a frame end");
  a_ok_kind: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.status != fhc_pkg::ST_OK) |-> (res.flow_kind == fhc_pkg::K_TCP4))
    else $error("error item carries a kind");
  a_status_range: assert property (@(posedge clk) disable iff (rst)
    (!empty) |-> (head.status <= fhc_pkg::ST_NOETYPE))
    else $error("bad status code");

endmodule

// ===== rtl/fhc_front.sv =====
module fhc_front #(
  parameter int MAX_FRAME_BYTES = fhc_pkg::MaxFrameBytes
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [1:0]        link_type,
  input  logic              restart,
  input  logic              take,
  input  logic [7:0]        frame_byte,
  input  logic              last_byte,
  output logic              snap_valid,
  output fhc_pkg::snap_t    snap
);

  localparam logic [16:0] MaxCount = 17'(MAX_FRAME_BYTES);

  logic [16:0]     byte_count;
  fhc_pkg::phase_t parse_phase;
  logic [15:0]     type_shift;
  logic [16:0]     ip_start;
  logic [7:0]      ip_header_bytes;
  logic [15:0]     ip_length_field;
  logic [7:0]      next_protocol;
  logic [63:0]     address_store [4];
  logic [15:0]     port_store [2];
  logic [2:0]      error_code;

  logic [16:0]     count_next;
  fhc_pkg::phase_t phase_next;
  logic [15:0]     shift_next;
  logic [16:0]     start_next;
  logic [7:0]      hdr_next;
  logic [15:0]     len_next;
  logic [7:0]      proto_next;
  logic [63:0]     addr_next [4];
  logic [15:0]     port_next [2];
  logic [2:0]      err_next;
  logic [16:0]     rel;
  logic [16:0]     prel;
  logic            counted;
  logic            do_ip;

  // per-byte parse step
  always_comb begin
    count_next = byte_count;
    phase_next = parse_phase;
    shift_next = type_shift;
    start_next = ip_start;
    hdr_next   = ip_header_bytes;
    len_next   = ip_length_field;
    proto_next = next_protocol;
    for (int i = 0; i < 4; i++) addr_next[i] = address_store[i];
    port_next[0] = port_store[0];
    port_next[1] = port_store[1];
    err_next = error_code;
    rel = 17'd0;
    prel = 17'd0;
    do_ip = 1'b0;
    counted = byte_count < MaxCount;
    if (counted) begin
      count_next = byte_count + 17'd1;
      do_ip = (parse_phase == fhc_pkg::PH_IP4) || (parse_phase == fhc_pkg::PH_IP6);
      if (parse_phase == fhc_pkg::PH_LINK) begin
        if (link_type == fhc_pkg::LINK_ETH) begin
          shift_next = {type_shift[7:0], frame_byte};
          if (byte_count == ip_start + 17'd13 && !last_byte) begin
            if (shift_next == fhc_pkg::ET_VLAN) begin
              start_next = ip_start + 17'd4;
            end else if (shift_next == fhc_pkg::ET_IP4) begin
              start_next = ip_start + 17'd14;
              phase_next = fhc_pkg::PH_IP4;
            end else if (shift_next == fhc_pkg::ET_IP6) begin
              start_next = ip_start + 17'd14;
              hdr_next = 8'd40;
              phase_next = fhc_pkg::PH_IP6;
            end else begin
              err_next = fhc_pkg::ST_ETYPE;
              phase_next = fhc_pkg::PH_DONE;
            end
          end
        end else if (byte_count ==
                     ((link_type == fhc_pkg::LINK_NULL) ? 17'd4 : 17'd0)) begin
          start_next = byte_count;
          phase_next = fhc_pkg::PH_IP4;
          do_ip = 1'b1;
        end
      end
      rel = byte_count - start_next;
      if (do_ip) begin
        if (phase_next == fhc_pkg::PH_IP4) begin
          if (rel == 17'd0) hdr_next = {2'b00, frame_byte[3:0], 2'b00};
          if (rel == 17'd2 || rel == 17'd3) len_next = {ip_length_field[7:0], frame_byte};
          if (rel == 17'd9) proto_next = frame_byte;
          if (rel >= 17'd12 && rel < 17'd16)
            addr_next[1] = {32'd0, address_store[1][23:0], frame_byte};
          if (rel >= 17'd16 && rel < 17'd20)
            addr_next[3] = {32'd0, address_store[3][23:0], frame_byte};
        end else begin
          if (rel == 17'd4 || rel == 17'd5) len_next = {ip_length_field[7:0], frame_byte};
          if (rel == 17'd6) proto_next = frame_byte;
          if (rel >= 17'd8 && rel < 17'd40)
            addr_next[rel[4:3] - 2'd1] = {address_store[rel[4:3] - 2'd1][55:0], frame_byte};
        end
        // ports use header length as known before this byte
        prel = rel - {9'd0, ip_header_bytes};
        if (rel >= {9'd0, ip_header_bytes} && prel < 17'd4)
          port_next[prel[1]] = {port_store[prel[1]][7:0], frame_byte};
      end
    end
  end

  // state registers, cleared at frame end and on restart
  always_ff @(posedge clk) begin
    if (rst || restart || (take && last_byte)) begin
      byte_count <= '0;
      parse_phase <= fhc_pkg::PH_LINK;
      type_shift <= '0;
      ip_start <= '0;
      ip_header_bytes <= '0;
      ip_length_field <= '0;
      next_protocol <= '0;
      for (int i = 0; i < 4; i++) address_store[i] <= '0;
      port_store[0] <= '0;
      port_store[1] <= '0;
      error_code <= '0;
    end else if (take) begin
      byte_count <= count_next;
      parse_phase <= phase_next;
      type_shift <= shift_next;
      ip_start <= start_next;
      ip_header_bytes <= hdr_next;
      ip_length_field <= len_next;
      next_protocol <= proto_next;
      for (int i = 0; i < 4; i++) address_store[i] <= addr_next[i];
      port_store[0] <= port_next[0];
      port_store[1] <= port_next[1];
      error_code <= err_next;
    end
  end

  // snapshot out at the last byte
  always_ff @(posedge clk) begin
    if (rst) begin
      snap_valid <= 1'b0;
    end else begin
      snap_valid <= take && last_byte;
    end
    snap.phase      <= phase_next;
    snap.link_type  <= link_type;
    snap.error_code <= err_next;
    snap.byte_count <= count_next;
    snap.ip_start   <= start_next;
    snap.hdr_bytes  <= hdr_next;
    snap.len_field  <= len_next;
    snap.proto      <= proto_next;
    snap.addr0      <= addr_next[0];
    snap.addr1      <= addr_next[1];
    snap.addr2      <= addr_next[2];
    snap.addr3      <= addr_next[3];
    snap.port0      <= port_next[0];
    snap.port1      <= port_next[1];
  end

endmodule

// ===== rtl/fhc_judge.sv =====
module fhc_judge (
  input  logic              clk,
  input  logic              rst,
  input  logic              snap_valid,
  input  fhc_pkg::snap_t    snap,
  output logic              res_valid,
  output fhc_pkg::result_t  res
);

  logic [16:0]       len;
  logic [16:0]       hl;
  logic [16:0]       tl;
  logic [2:0]        st;
  logic [2:0]        kind;
  logic              ports;
  fhc_pkg::result_t  r;

  // classify and check lengths
  always_comb begin
    len = snap.byte_count - snap.ip_start;
    hl = {9'd0, snap.hdr_bytes};
    tl = {1'b0, snap.len_field};
    kind = fhc_pkg::K_TCP4;
    st = fhc_pkg::ST_OK;
    case (snap.phase)
      fhc_pkg::PH_LINK: begin
        st = (snap.link_type == fhc_pkg::LINK_ETH && snap.byte_count >= 17'd14) ?
             fhc_pkg::ST_NOETYPE : fhc_pkg::ST_TRUNC;
      end
      fhc_pkg::PH_DONE: st = snap.error_code;
      fhc_pkg::PH_IP4: begin
        if (len < 17'd20 || len < tl || len < hl || tl < hl) st = fhc_pkg::ST_TRUNC;
        else if (snap.proto == 8'd6) begin
          kind = fhc_pkg::K_TCP4;
          st = (len < hl + 17'd20) ? fhc_pkg::ST_TRUNC : fhc_pkg::ST_OK;
        end else if (snap.proto == 8'd17) begin
          kind = fhc_pkg::K_UDP4;
          st = (len < hl + 17'd8) ? fhc_pkg::ST_TRUNC : fhc_pkg::ST_OK;
        end else if (snap.proto == 8'd1) kind = fhc_pkg::K_ICMP4;
        else st = fhc_pkg::ST_PROTO;
      end
      default: begin
        if (len < 17'd40 || len < tl) st = fhc_pkg::ST_TRUNC;
        else if (snap.proto == 8'd6) begin
          kind = fhc_pkg::K_TCP6;
          st = (len < 17'd60) ? fhc_pkg::ST_TRUNC : fhc_pkg::ST_OK;
        end else if (snap.proto == 8'd17) begin
          kind = fhc_pkg::K_UDP6;
          st = (len < 17'd48) ? fhc_pkg::ST_TRUNC : fhc_pkg::ST_OK;
        end else if (snap.proto == 8'd1 || snap.proto == 8'd58) kind = fhc_pkg::K_ICMP6;
        else st = fhc_pkg::ST_PROTO;
      end
    endcase
    ports = kind != fhc_pkg::K_ICMP4 && kind != fhc_pkg::K_ICMP6;
    r = '0;
    r.status = st;
    if (st == fhc_pkg::ST_OK) begin
      r.flow_kind = kind;
      r.ip_offset = snap.ip_start[15:0];
      r.payload_offset = snap.ip_start[15:0] + {8'd0, snap.hdr_bytes};
      r.payload_length = (snap.phase == fhc_pkg::PH_IP4) ?
                         snap.len_field - {8'd0, snap.hdr_bytes} : snap.len_field;
      r.source_high = snap.addr0;
      r.source_low = snap.addr1;
      r.dest_high = snap.addr2;
      r.dest_low = snap.addr3;
      r.source_port = ports ? snap.port0 : 16'd0;
      r.dest_port = ports ? snap.port1 : 16'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else begin
      res_valid <= snap_valid;
    end
    res <= r;
  end

endmodule

// ===== rtl/fhc_queue.sv =====
module fhc_queue #(
  parameter int DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr,
  input  fhc_pkg::result_t  wdata,
  input  logic              rd,
  output logic              empty,
  output logic              almost_full,
  output fhc_pkg::result_t  rdata
);

  localparam int AW = $clog2(DEPTH);

  fhc_pkg::result_t mem [DEPTH];
  logic [AW-1:0]    wptr;
  logic [AW-1:0]    rptr;
  logic [AW:0]      count;

  assign empty = count == '0;
  // room kept for the two items in flight behind the input
  assign almost_full = count >= (AW + 1)'(DEPTH - 2);
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (wr) mem[wptr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      if (wr) wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : wptr + AW'(1);
      if (rd && !empty) rptr <= (rptr == AW'(DEPTH - 1)) ? '0 : rptr + AW'(1);
      count <= count + (AW + 1)'(wr) - (AW + 1)'(rd && !empty);
    end
  end

endmodule
